// ===== sv/pems_pkg.sv =====
// Shared types, codes and helper functions for the mutate-and-select block.
// No dependencies; used by pems_eval and pareto_ea_mutate_select.
package pems_pkg;

  localparam int unsigned FIELD_W = 64;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned GEN_W   = 32;

  localparam logic [GEN_W-1:0] GEN_MAX = '1;

  // Opcodes of the input request
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Configuration register indexes
  localparam logic CFG_WIDTH_IDX = 1'b0;
  localparam logic CFG_PESS_IDX  = 1'b1;

  localparam logic [CNT_W-1:0] WIDTH_RST = 7'd64;

  typedef logic [FIELD_W-1:0] bits_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [GEN_W-1:0]   gen_t;

  typedef struct packed {
    logic  accepted;
    cnt_t  zero_count;
    gen_t  generation;
    logic  finished;
    bits_t parent;
  } res_t;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + {3'b000, v[i]};
    end
    return c;
  endfunction

  // Byte counts first, then an eight-way sum
  function automatic cnt_t popcount64(input bits_t v);
    cnt_t c;
    c = '0;
    for (int b = 0; b < 8; b++) begin
      c = c + {3'b000, popcount8(v[b*8 +: 8])};
    end
    return c;
  endfunction

endpackage

// ===== sv/pems_eval.sv =====
// Combinational evaluation of one request: load, or mutate and select.
// Depends on pems_pkg for types, opcodes and popcount.
module pems_eval #(
  parameter int unsigned MAX_BITS = 64
) (
  input  logic            opcode,
  input  pems_pkg::bits_t bits_value,
  input  pems_pkg::bits_t parent,
  input  pems_pkg::gen_t  generation,
  input  pems_pkg::cnt_t  width_cfg,
  input  logic            pessimistic,
  output pems_pkg::res_t  res
);

  localparam pems_pkg::cnt_t MAXW = pems_pkg::cnt_t'(MAX_BITS);

  pems_pkg::cnt_t  w;
  pems_pkg::bits_t m;
  pems_pkg::bits_t par;
  pems_pkg::bits_t load_bits;
  pems_pkg::bits_t flips;
  pems_pkg::bits_t on_zero;
  pems_pkg::bits_t lowest;
  pems_pkg::bits_t child;
  pems_pkg::cnt_t  par_zeros;
  pems_pkg::cnt_t  child_zeros;
  pems_pkg::cnt_t  load_zeros;
  logic            running;
  logic            child_dom;
  logic            parent_dom;
  logic            take;

  // Clamp the width in use to [1, MAX_BITS]
  always_comb begin
    if (width_cfg == '0) begin
      w = pems_pkg::cnt_t'(1);
    end else if (width_cfg > MAXW) begin
      w = MAXW;
    end else begin
      w = width_cfg;
    end
  end

  always_comb begin
    for (int i = 0; i < pems_pkg::FIELD_W; i++) begin
      m[i] = (pems_pkg::cnt_t'(i) < w);
    end
  end

  always_comb begin
    par        = parent & m;
    load_bits  = bits_value & m;
    par_zeros  = w - pems_pkg::popcount64(par);
    load_zeros = w - pems_pkg::popcount64(load_bits);
    running    = (par_zeros != '0);

    flips   = bits_value & m;
    on_zero = flips & ~par;
    lowest  = on_zero & (~on_zero + pems_pkg::bits_t'(1));
    if (pessimistic) begin
      flips = (flips & par) | lowest;
    end
    child       = (par ^ flips) & m;
    child_zeros = w - pems_pkg::popcount64(child);
    child_dom   = ((par & ~child) == '0);
    parent_dom  = ((child & ~par) == '0);
    take        = child_dom || (!parent_dom && (child_zeros > par_zeros));
  end

  always_comb begin
    res.accepted   = 1'b0;
    res.zero_count = par_zeros;
    res.generation = generation;
    res.parent     = par;
    if (opcode == pems_pkg::OP_LOAD) begin
      res.parent     = load_bits;
      res.zero_count = load_zeros;
      res.generation = pems_pkg::gen_t'(1);
    end else if (running) begin
      if (generation != pems_pkg::GEN_MAX) begin
        res.generation = generation + pems_pkg::gen_t'(1);
      end
      if (take) begin
        res.parent     = child;
        res.zero_count = child_zeros;
        res.accepted   = 1'b1;
      end
    end
    res.finished = (res.zero_count == '0);
  end

endmodule

// ===== sv/pareto_ea_mutate_select.sv =====
// Top level of the (1+1) evolutionary mutate-and-select step.
// Depends on pems_pkg and pems_eval.
//
// Usage:
//   Input channel (in_valid / in_stall): each request carries in_opcode and
//   in_bits_value. A load request sets the parent bit string and restarts the
//   generation count at 1; a step request supplies a random flip mask, forms
//   a child and keeps it if it dominates or has more zeros when incomparable.
//   Result channel (out_valid / out_stall): one result per request, in order,
//   with the accept flag, zero count, generation count, finished flag and the
//   parent after the request.
//   Config channel (cfg_valid / cfg_ready): index 0 sets width_in_use,
//   index 1 sets pessimistic_mode. Always ready; write only while idle.
// Pipeline: a request passes the input register, then the result register.
//   One request per cycle is sustained while out_stall is low; the parent
//   feedback runs from parent_r through the combinational evaluation logic.
// Reset: rst_n clears the valid bits of both pipeline stages, the parent and
//   the generation count, and sets width_in_use to 64 and pessimistic_mode to 0.
// Stall: while out_stall holds a full result register, the input register
//   holds its request and in_stall rises; no request is lost or repeated.
module pareto_ea_mutate_select #(
  parameter int unsigned MAX_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [63:0] in_bits_value,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic [6:0]  out_zero_count,
  output logic [31:0] out_generation_count,
  output logic        out_finished,
  output logic [63:0] out_parent_out,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  // Input register
  logic                   in_valid_r;
  logic                   in_opcode_r;
  pems_pkg::bits_t        in_bits_r;

  // Result register
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  pems_pkg::res_t         out_res_r;

  // Block state and configuration
  logic [MAX_BITS-1:0]    parent_r;
  pems_pkg::gen_t         gen_r;
  pems_pkg::cnt_t         width_r;
  logic                   pess_r;

  logic                   advance;
  logic                   fire;
  pems_pkg::res_t         res;

  // Result register frees up when empty or when its result is taken
  assign advance   = !out_valid_r || !out_stall;
  assign fire      = in_valid_r && advance;
  assign in_stall  = in_valid_r && !advance;
  assign cfg_ready = 1'b1;

  assign out_valid_nxt = advance ? in_valid_r : out_valid_r;

  pems_eval #(
    .MAX_BITS (MAX_BITS)
  ) u_eval (
    .opcode      (in_opcode_r),
    .bits_value  (in_bits_r),
    .parent      (pems_pkg::FIELD_W'(parent_r)),
    .generation  (gen_r),
    .width_cfg   (width_r),
    .pessimistic (pess_r),
    .res         (res)
  );

  // Take a new request whenever the input register is not held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_opcode_r <= in_opcode;
      in_bits_r   <= in_bits_value;
    end
  end

  // Advance the result register and commit the new state together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      parent_r    <= '0;
      gen_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        parent_r <= res.parent[MAX_BITS-1:0];
        gen_r    <= res.generation;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= pems_pkg::WIDTH_RST;
      pess_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pems_pkg::CFG_WIDTH_IDX: width_r <= cfg_data;
        pems_pkg::CFG_PESS_IDX:  pess_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_accepted         = out_res_r.accepted;
  assign out_zero_count       = out_res_r.zero_count;
  assign out_generation_count = out_res_r.generation;
  assign out_finished         = out_res_r.finished;
  assign out_parent_out       = out_res_r.parent;

`ifndef SYNTHESIS
  // A step never lowers the generation count
  a_gen_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_opcode_r == pems_pkg::OP_STEP) |=> (gen_r >= $past(gen_r)))
    else $error("generation count decreased on a step");

  // A load always restarts the count at one
  a_load_gen: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_opcode_r == pems_pkg::OP_LOAD) |=> (gen_r == pems_pkg::gen_t'(1)))
    else $error("load did not restart generation count");

  // An accepted child implies at least one generation has run
  a_accept_gen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.accepted) |-> (out_res_r.generation != '0))
    else $error("accepted result with zero generation count");
`endif

endmodule
